FILE: hw/rtl/dgf_pkg.sv
// dgf_pkg: types, sequencer states and fixed-point constants for the digamma unit.
// No dependencies; used by dgf_divider and digamma_function_unit.
package dgf_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int ATANH_TERMS       = 11;

    localparam logic [63:0] ONE_Q32 = 64'd1 << 32;
    localparam logic [31:0] C12     = 32'((ONE_Q32 + 64'd6) / 64'd12);
    localparam logic [31:0] C120    = 32'((ONE_Q32 + 64'd60) / 64'd120);
    localparam logic [31:0] C252    = 32'((ONE_Q32 + 64'd126) / 64'd252);
    localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

    typedef enum logic [4:0] {
        S_IDLE, S_LOOP, S_W_LOOP, S_W_U,
        S_U2, S_U2W, S_T1, S_T1W, S_T2, S_T2W, S_SER, S_SERW,
        S_NORM, S_ZDIV, S_ZW, S_Z2, S_Z2W, S_P, S_PW, S_TD, S_TW,
        S_KLN, S_KLNW, S_ABS, S_FIN, S_OUT
    } state_t;

    typedef struct packed {
        logic        start;
        logic [6:0]  nbits;
        logic [63:0] dividend;
        logic [33:0] divisor;
    } div_req_t;

endpackage

FILE: hw/rtl/dgf_divider.sv
// dgf_divider: restoring divider, one quotient bit per cycle.
// Depends on dgf_pkg (div_req_t).
module dgf_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  dgf_pkg::div_req_t req,
    output logic              done,
    output logic [63:0]       quotient
);

    logic        busy_reg;
    logic        done_reg;
    logic [6:0]  cnt_reg;
    logic [33:0] rem_reg;
    logic [33:0] dvs_reg;
    logic [63:0] dvd_reg;
    logic [63:0] quo_reg;
    logic [35:0] diff;
    logic        ge;

    // divisor is held for the whole division
    assign diff = {1'b0, rem_reg, dvd_reg[63]} - {2'b00, dvs_reg};
    assign ge   = !diff[35];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.nbits;
                rem_reg  <= '0;
                quo_reg  <= '0;
                dvs_reg  <= req.divisor;
                dvd_reg  <= req.dividend << (7'd64 - req.nbits);
            end else if (busy_reg) begin
                rem_reg  <= ge ? diff[33:0] : {rem_reg[32:0], dvd_reg[63]};
                quo_reg  <= {quo_reg[62:0], ge};
                dvd_reg  <= {dvd_reg[62:0], 1'b0};
                cnt_reg  <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hw/rtl/digamma_function_unit.sv
// digamma_function_unit: fixed-point digamma psi(x), shared divider and multiplier.
// Depends on dgf_pkg and dgf_divider.
//
// Usage:
//   Input channel s_valid/s_ready/s_x_value carries one word: x, unsigned
//   fixed point with FRAC_BITS fraction bits. Result channel m_valid/m_ready
//   carries psi(x) as signed Q24.24 on m_psi_value plus m_invalid.
//   x == 0 is the pole: m_invalid = 1, m_psi_value = 0, m_valid the cycle
//   right after the word is accepted.
//   Otherwise a small sequencer drives one bit-serial divider (one quotient
//   bit a cycle) and one 32x32 multiplier. Each reciprocal and each atanh
//   term takes one division; the 11-term atanh series also needs the z
//   division and the normalize shift. Small x (below six) adds at most six
//   extra reciprocals.
//   One word at a time: s_ready is high only when idle. The result is held
//   in an output register until taken; a stall on m_ready just holds it.
//   Reset (aresetn, synchronous, active low) returns to idle, no output.
//   Very negative results saturate to -2^47.
module digamma_function_unit #(
    parameter int FRAC_BITS = dgf_pkg::FRAC_BITS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_x_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [47:0] m_psi_value,
    output logic               m_invalid
);

    localparam logic [31:0] ONE_X = 32'd1 << FRAC_BITS;
    localparam logic [31:0] SIX_X = 32'd6 << FRAC_BITS;
    localparam logic [63:0] RNUM  = 64'd1 << (32 + FRAC_BITS);
    localparam logic [6:0]  RBITS = 7'(33 + FRAC_BITS);

    dgf_pkg::state_t   state_reg, state_next;
    dgf_pkg::div_req_t div_req;
    logic              div_done;
    logic [63:0]       div_quo;

    logic [31:0]        xr_reg, xn_reg;
    logic signed [63:0] acc_reg;
    logic [31:0]        u_reg, u2_reg, t_reg, z_reg, z2_reg, p_reg;
    logic [4:0]         e_reg;
    logic [3:0]         j_reg;
    logic               neg_reg;
    logic [63:0]        prod_reg;
    logic [47:0]        psi_reg;
    logic               inv_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] rnd_sum;
    logic [31:0] rnd;
    logic [33:0] zden;
    logic [63:0] acc_mag;
    logic [55:0] mag_r;

    assign rnd_sum = prod_reg + 64'h0000_0000_8000_0000;
    assign rnd     = rnd_sum[63:32];
    // m = 1.frac, den = m + 1 in Q.32
    assign zden    = {1'b0, xn_reg, 1'b0} + 34'(dgf_pkg::ONE_Q32);
    assign acc_mag = 64'(acc_reg) + 64'd128;
    assign mag_r   = acc_mag[63:8];

    dgf_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dgf_pkg::S_IDLE:   if (s_valid) state_next = (s_x_value == '0) ?
                                   dgf_pkg::S_OUT : dgf_pkg::S_LOOP;
            dgf_pkg::S_LOOP:   state_next = (xr_reg < SIX_X) ?
                                   dgf_pkg::S_W_LOOP : dgf_pkg::S_W_U;
            dgf_pkg::S_W_LOOP: if (div_done) state_next = dgf_pkg::S_LOOP;
            dgf_pkg::S_W_U:    if (div_done) state_next = dgf_pkg::S_U2;
            dgf_pkg::S_U2:     state_next = dgf_pkg::S_U2W;
            dgf_pkg::S_U2W:    state_next = dgf_pkg::S_T1;
            dgf_pkg::S_T1:     state_next = dgf_pkg::S_T1W;
            dgf_pkg::S_T1W:    state_next = dgf_pkg::S_T2;
            dgf_pkg::S_T2:     state_next = dgf_pkg::S_T2W;
            dgf_pkg::S_T2W:    state_next = dgf_pkg::S_SER;
            dgf_pkg::S_SER:    state_next = dgf_pkg::S_SERW;
            dgf_pkg::S_SERW:   state_next = dgf_pkg::S_NORM;
            dgf_pkg::S_NORM:   if (xn_reg[31]) state_next = dgf_pkg::S_ZDIV;
            dgf_pkg::S_ZDIV:   state_next = dgf_pkg::S_ZW;
            dgf_pkg::S_ZW:     if (div_done) state_next = dgf_pkg::S_Z2;
            dgf_pkg::S_Z2:     state_next = dgf_pkg::S_Z2W;
            dgf_pkg::S_Z2W:    state_next = dgf_pkg::S_P;
            dgf_pkg::S_P:      state_next = dgf_pkg::S_PW;
            dgf_pkg::S_PW:     state_next = dgf_pkg::S_TD;
            dgf_pkg::S_TD:     state_next = dgf_pkg::S_TW;
            dgf_pkg::S_TW:     if (div_done) state_next =
                                   (j_reg == 4'(dgf_pkg::ATANH_TERMS)) ?
                                   dgf_pkg::S_KLN : dgf_pkg::S_P;
            dgf_pkg::S_KLN:    state_next = dgf_pkg::S_KLNW;
            dgf_pkg::S_KLNW:   state_next = dgf_pkg::S_ABS;
            dgf_pkg::S_ABS:    state_next = dgf_pkg::S_FIN;
            dgf_pkg::S_FIN:    state_next = dgf_pkg::S_OUT;
            dgf_pkg::S_OUT:    if (m_ready) state_next = dgf_pkg::S_IDLE;
            default:           state_next = dgf_pkg::S_IDLE;
        endcase
    end

    // outputs: handshake, divider request, multiplier operands
    always_comb begin
        s_ready          = (state_reg == dgf_pkg::S_IDLE);
        m_valid          = (state_reg == dgf_pkg::S_OUT);
        div_req.start    = 1'b0;
        div_req.nbits    = RBITS;
        div_req.dividend = RNUM + 64'(xr_reg >> 1);
        div_req.divisor  = 34'(xr_reg);
        mul_a            = '0;
        mul_b            = '0;
        unique case (state_reg)
            dgf_pkg::S_LOOP: div_req.start = 1'b1;
            dgf_pkg::S_ZDIV: begin
                div_req.start    = 1'b1;
                div_req.nbits    = 7'd64;
                div_req.dividend = {xn_reg[30:0], 33'd0} + 64'(zden >> 1);
                div_req.divisor  = zden;
            end
            dgf_pkg::S_TD: begin
                // (p + d/2) / d with d = 2j+1
                div_req.start    = 1'b1;
                div_req.nbits    = 7'd33;
                div_req.dividend = 64'(p_reg) + 64'(j_reg);
                div_req.divisor  = 34'({j_reg, 1'b1});
            end
            dgf_pkg::S_U2:  begin mul_a = u_reg;  mul_b = u_reg;  end
            dgf_pkg::S_T1:  begin mul_a = u2_reg; mul_b = dgf_pkg::C252; end
            dgf_pkg::S_T2,
            dgf_pkg::S_SER: begin mul_a = u2_reg; mul_b = t_reg;  end
            dgf_pkg::S_Z2:  begin mul_a = z_reg;  mul_b = z_reg;  end
            dgf_pkg::S_P:   begin mul_a = p_reg;  mul_b = z2_reg; end
            dgf_pkg::S_KLN: begin
                mul_a = 32'(e_reg) - 32'(FRAC_BITS);
                mul_b = dgf_pkg::LN2_Q32;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= dgf_pkg::S_IDLE;
        else          state_reg <= state_next;
    end

    // datapath
    always_ff @(posedge aclk) begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
        case (state_reg)
            dgf_pkg::S_IDLE: if (s_valid) begin
                xr_reg  <= s_x_value;
                acc_reg <= '0;
                psi_reg <= '0;
                inv_reg <= (s_x_value == '0);
            end
            dgf_pkg::S_W_LOOP: if (div_done) begin
                acc_reg <= acc_reg - $signed(div_quo);
                xr_reg  <= xr_reg + ONE_X;
            end
            dgf_pkg::S_W_U: if (div_done) begin
                u_reg   <= div_quo[31:0];
                acc_reg <= acc_reg - $signed((div_quo + 64'd1) >> 1);
            end
            dgf_pkg::S_U2W: u2_reg <= rnd;
            dgf_pkg::S_T1W: t_reg  <= dgf_pkg::C120 - rnd;
            dgf_pkg::S_T2W: t_reg  <= dgf_pkg::C12 - rnd;
            dgf_pkg::S_SERW: begin
                acc_reg <= acc_reg - $signed({32'd0, rnd});
                xn_reg  <= xr_reg;
                e_reg   <= 5'd31;
            end
            dgf_pkg::S_NORM: if (!xn_reg[31]) begin
                xn_reg <= {xn_reg[30:0], 1'b0};
                e_reg  <= e_reg - 5'd1;
            end
            dgf_pkg::S_ZW: if (div_done) begin
                z_reg   <= div_quo[31:0];
                p_reg   <= div_quo[31:0];
                acc_reg <= acc_reg + $signed({div_quo[62:0], 1'b0});
            end
            dgf_pkg::S_Z2W: begin
                z2_reg <= rnd;
                j_reg  <= 4'd1;
            end
            dgf_pkg::S_PW: p_reg <= rnd;
            dgf_pkg::S_TW: if (div_done) begin
                acc_reg <= acc_reg + $signed({div_quo[62:0], 1'b0});
                j_reg   <= j_reg + 4'd1;
            end
            dgf_pkg::S_KLNW: acc_reg <= acc_reg + $signed(prod_reg);
            dgf_pkg::S_ABS: begin
                neg_reg <= acc_reg[63];
                if (acc_reg[63]) acc_reg <= -acc_reg;
            end
            dgf_pkg::S_FIN: begin
                // round half away from zero to Q24.24, then saturate
                if (neg_reg)
                    psi_reg <= (mag_r[55:47] != '0) ? 48'h8000_0000_0000 : -mag_r[47:0];
                else
                    psi_reg <= (mag_r[55:47] != '0) ? 48'h7FFF_FFFF_FFFF : mag_r[47:0];
            end
            default: ;
        endcase
    end

    assign m_psi_value = $signed(psi_reg);
    assign m_invalid   = inv_reg;

`ifndef ASSERT_OFF
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("ready and result valid at once");

    a_pole: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_x_value == '0) |=> (m_valid && m_invalid))
        else $error("pole word did not give invalid result");

    a_inv_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_invalid) |-> (m_psi_value == '0))
        else $error("invalid result not zero");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == dgf_pkg::S_W_LOOP || state_reg == dgf_pkg::S_W_U ||
                      state_reg == dgf_pkg::S_ZW || state_reg == dgf_pkg::S_TW))
        else $error("divider finished outside a wait state");
`endif

endmodule

FILE: tb/tb_top.sv
// tb_top: randomized self-checking bench for digamma_function_unit.
// Needs the RTL only (dgf_pkg, dgf_divider, digamma_function_unit); the
// expected value is computed with exact integer arithmetic inside the bench.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = dgf_pkg::FRAC_BITS_DEFAULT;

    // Golden digamma in integer math (128-bit products), Q.32 internally, Q24.24 out.
    function automatic logic [63:0] mulq(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b) + (128'd1 << 31);
        return p[95:32];
    endfunction

    function automatic logic [63:0] recip(logic [63:0] xr);
        logic [63:0] num;
        num = 64'd1 << (32 + FRAC);
        return (num + xr / 2) / xr;
    endfunction

    function automatic logic [63:0] ln_of(logic [63:0] xr);
        int          e;
        logic [63:0] m, num, den, z, z2, sum, p, d, k;
        e = 31;
        while (e > 0 && xr[e] == 1'b0) e--;
        m   = xr << (32 - e);
        num = (m - (64'd1 << 32)) << 32;
        den = m + (64'd1 << 32);
        z   = (num + den / 2) / den;
        z2  = mulq(z, z);
        sum = z;
        p   = z;
        for (int j = 1; j <= 11; j++) begin
            d   = 64'(2 * j + 1);
            p   = mulq(p, z2);
            sum = sum + (p + d / 2) / d;
        end
        k = 64'(signed'(e - FRAC));
        return k * 64'hB17217F8 + 2 * sum;
    endfunction

    function automatic logic [47:0] psi_of(logic [31:0] xv);
        logic [63:0]        xr, u, u2, t, ser, mag;
        logic signed [63:0] acc;
        logic               neg;
        logic [63:0]        c12, c120, c252;
        c12  = ((64'd1 << 32) + 6) / 12;
        c120 = ((64'd1 << 32) + 60) / 120;
        c252 = ((64'd1 << 32) + 126) / 252;
        xr  = 64'(xv);
        acc = 0;
        while (xr < (64'd6 << FRAC)) begin
            acc = acc - signed'(recip(xr));
            xr  = xr + (64'd1 << FRAC);
        end
        u   = recip(xr);
        u2  = mulq(u, u);
        t   = c120 - mulq(u2, c252);
        t   = c12 - mulq(u2, t);
        ser = mulq(u2, t);
        acc = acc + signed'(ln_of(xr)) - signed'((u + 1) >> 1) - signed'(ser);
        neg = acc < 0;
        mag = neg ? 64'(-acc) : 64'(acc);
        mag = (mag + 128) >> 8;
        if (neg) return (mag >= (64'd1 << 47)) ? 48'h8000_0000_0000 : 48'(-mag);
        return (mag > 64'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : mag[47:0];
    endfunction

    // Scoreboard: queue of expected (psi, invalid) words.
    class psi_scoreboard;
        logic [48:0] pending[$];
        int          errors;

        function void note_x(logic [31:0] xv);
            if (xv == 0) pending.push_back({48'd0, 1'b1});
            else         pending.push_back({psi_of(xv), 1'b0});
        endfunction

        function void check_word(logic [47:0] psi, logic inv);
            logic [48:0] want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result psi=%h invalid=%b", $time, psi, inv);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (want[48:1] !== psi) begin
                $display("%0t: psi mismatch exp %h got %h", $time, want[48:1], psi);
                errors++;
            end
            if (want[0] !== inv) begin
                $display("%0t: invalid mismatch exp %b got %b", $time, want[0], inv);
                errors++;
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [31:0]        s_x_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [47:0] m_psi_value;
    logic               m_invalid;

    psi_scoreboard sb = new();
    bit            stim_done = 1'b0;

    always #5 aclk = ~aclk;

    digamma_function_unit i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_x_value  (s_x_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_psi_value(m_psi_value),
        .m_invalid  (m_invalid)
    );

    // Gap length: mostly short, occasionally long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // Drive one word; valid holds until the handshake edge.
    task automatic send_x(logic [31:0] xv);
        s_valid   <= 1'b1;
        s_x_value <= xv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_x(xv);
    endtask

    // Drop valid for the given gap; with n == 0 valid stays up for the next word.
    task automatic idle_cycles(int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Random argument: mix of tiny, below-six, near-six, mid and full-range values.
    function automatic logic [31:0] rand_x();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 255);
            1: return $urandom_range(1, (6 << FRAC) - 1);
            2: return $urandom_range((6 << FRAC) - 16, (6 << FRAC) + 16);
            3: return $urandom_range(1 << FRAC, 1000 << FRAC);
            default: return $urandom();
        endcase
    endfunction

    initial begin
        logic [31:0] directed[$];
        int          g;
        directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'(1 << FRAC), 32'(2 << FRAC), 32'(FRAC'(1) << (FRAC - 1)),
                     32'((6 << FRAC) - 1), 32'(6 << FRAC), 32'((6 << FRAC) + 1),
                     32'(7 << FRAC), 32'h0001_8000, 32'd0};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed[i]) begin
            send_x(directed[i]);
            if ($urandom_range(0, 2) == 0) idle_cycles(gap_len());
        end
        for (int n = 0; n < 1200; n++) begin
            send_x(rand_x());
            // Stretches without gaps, then stretches with them.
            if ((n / 100) % 2 == 1) begin
                g = gap_len();
                idle_cycles(g);
            end
        end
        s_valid   <= 1'b0;
        stim_done = 1'b1;
    end

    // Result side: random backpressure, check on each accepted word.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_word(m_psi_value, m_invalid);
            m_ready <= ($urandom_range(0, 9) < 7) || ($time / 50000) % 3 == 0;
        end
    end

    initial begin
        wait (stim_done);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (1000) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("digamma_function_unit verification clean");
        else
            $display("digamma_function_unit verification failed");
        $finish;
    end

    // Timeout for the slowest run: ~1220 items, each with busy, gap and stall time.
    initial begin
        #100ms;
        $display("digamma_function_unit verification failed");
        $finish;
    end
endmodule
